FILE: rtl/aes_pkg.sv
// ---------------------------------------------------------------------------
// aes_pkg
// shared types, constants and round functions for the aes-128 block pipeline
// ---------------------------------------------------------------------------
package aes_pkg;

    localparam int ROUNDS = 10;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [ROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW  = 2'd1;

    typedef logic [127:0] block_t;

    // byte i of the block at bits [127-8i -: 8]
    function automatic logic [7:0] get_byte(input block_t b, input int i);
        get_byte = b[127 - 8 * i -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic block_t next_key(input block_t k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = sub_word({w3[23:0], w3[31:24]}) ^ {rc, 24'h0};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        next_key = {w0, w1, w2, w3};
    endfunction

    function automatic block_t round_fn(input block_t s, input block_t k, input logic last);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3;
        block_t o;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                t[r + 4 * c] = SBOX[get_byte(s, r + 4 * ((c + r) % 4))];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[4 * c];
            a1 = t[4 * c + 1];
            a2 = t[4 * c + 2];
            a3 = t[4 * c + 3];
            if (!last)
            begin
                x0 = xtime(a0);
                x1 = xtime(a1);
                x2 = xtime(a2);
                x3 = xtime(a3);
                t[4 * c]     = x0 ^ x1 ^ a1 ^ a2 ^ a3;
                t[4 * c + 1] = a0 ^ x1 ^ x2 ^ a2 ^ a3;
                t[4 * c + 2] = a0 ^ a1 ^ x2 ^ x3 ^ a3;
                t[4 * c + 3] = x0 ^ a0 ^ a1 ^ a2 ^ x3;
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            o[127 - 8 * i -: 8] = t[i];
        end
        round_fn = o ^ k;
    endfunction

endpackage

FILE: rtl/aes_round_cell.sv
// ---------------------------------------------------------------------------
// aes_round_cell
// one round stage: state register with valid, advances when enabled
// ---------------------------------------------------------------------------
module aes_round_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              last,
    input  logic              in_valid,
    input  aes_pkg::block_t   in_state,
    input  aes_pkg::block_t   round_key,
    output logic              out_valid,
    output aes_pkg::block_t   out_state
);

    logic            valid_reg;
    aes_pkg::block_t state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= aes_pkg::round_fn(in_state, round_key, last);
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;

endmodule

FILE: rtl/aes_key_cell.sv
// ---------------------------------------------------------------------------
// aes_key_cell
// one key schedule step: derives and holds the next round key
// ---------------------------------------------------------------------------
module aes_key_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic [7:0]        rcon,
    input  aes_pkg::block_t   prev_key,
    output aes_pkg::block_t   key
);

    aes_pkg::block_t key_reg;
    aes_pkg::block_t key_next;

    assign key_next = aes_pkg::next_key(prev_key, rcon);

    // keys ripple down the row one cell per cycle while load is high after a key write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (load)
        begin
            key_reg <= key_next;
        end
    end

    assign key = key_reg;

endmodule

FILE: rtl/aes128_block_encrypt.sv
// ---------------------------------------------------------------------------
// aes128_block_encrypt
// aes-128 encryption pipeline of ten round cells under a configured key
// ---------------------------------------------------------------------------
// Accepts one 128-bit block per cycle while in_stall is low. Each block passes
// an input key-add register and then ten round cells to the output. The input
// register and the round cells (never the key cells) hold only while the last
// stage has a beat that the output side stalls; the input stall follows that
// condition in the same cycle. A key write takes effect for every block accepted
// after the write edge: round key g is rebuilt through g registered key cells,
// before a block accepted next can reach round g, so no wait is needed. Write
// keys only while no block is in flight.
module aes128_block_encrypt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] plain_high,
    input  logic [63:0] plain_low,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] cipher_high,
    output logic [63:0] cipher_low
);

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    aes_pkg::block_t keys [aes_pkg::ROUNDS + 1];
    logic            v [aes_pkg::ROUNDS + 1];
    aes_pkg::block_t s [aes_pkg::ROUNDS + 1];
    logic            en;
    logic            v0_reg;
    aes_pkg::block_t s0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                aes_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                aes_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign keys[0] = {key_high_reg, key_low_reg};

    // pipeline stalls as a whole when the last stage holds an untaken beat
    assign en       = !(v[aes_pkg::ROUNDS] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg <= {plain_high, plain_low} ^ keys[0];
        end
    end

    assign v[0] = v0_reg;
    assign s[0] = s0_reg;

    for (genvar g = 0; g < aes_pkg::ROUNDS; g++)
    begin : g_row
        aes_key_cell u_key (
            .clk      (clk),
            .rst_n    (rst_n),
            .load     (1'b1),
            .rcon     (aes_pkg::RCON[g]),
            .prev_key (keys[g]),
            .key      (keys[g + 1])
        );
        aes_round_cell u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .last      (g == aes_pkg::ROUNDS - 1),
            .in_valid  (v[g]),
            .in_state  (s[g]),
            .round_key (keys[g + 1]),
            .out_valid (v[g + 1]),
            .out_state (s[g + 1])
        );
    end

    assign out_valid   = v[aes_pkg::ROUNDS];
    assign cipher_high = s[aes_pkg::ROUNDS][127:64];
    assign cipher_low  = s[aes_pkg::ROUNDS][63:0];

`ifndef SYNTH
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cipher_high) && $stable(cipher_low))
        else $error("output beat changed under stall");
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow output stall");
    a_first_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall && in_valid |=> v0_reg)
        else $error("accepted beat lost at pipeline entry");
`endif

endmodule
